// ===== rtl/assert_macros.svh =====
// Assertion macros included by bqzc_ctrl.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bqzc_pkg.sv =====
// Shared constants and types for the biquad band-pass zero-crossing block
package bqzc_pkg;
	localparam int STAGES  = 2;
	localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int SMP_W   = 16;
	localparam int PROD_W  = 2 * SMP_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int TAP_W   = 3;
	localparam int RUN_W   = 8;
	localparam int CNT_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W   = 48;

	// tap sequence within one section
	localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
	localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
	localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
	localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
	localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_S0_FF   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_S0_FB   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_S1_FF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_S1_FB   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POST_SH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_THR = 3'd5;

	// register defaults
	localparam logic [47:0] S0_FF_RST = 48'h3E97_82D1_3E97;
	localparam logic [31:0] S0_FB_RST = 32'hC2C9_7D27;
	localparam logic [47:0] S1_FF_RST = 48'h0257_04AE_0257;
	localparam logic [31:0] S1_FB_RST = 32'hDD9F_5903;
	localparam logic [1:0]  POST_SH_RST = 2'd1;
	localparam logic [RUN_W-1:0] RUN_THR_RST = 8'd3;

	typedef struct packed {
		logic               load;     // latch new sample, clear accumulator
		logic               mul;      // form product for current tap
		logic               acc;      // add previous product
		logic               fin;      // close section: shift, saturate, shift history
		logic               out_load; // update run counter, fill output register
		logic [TAP_W-1:0]   tap;
		logic [STAGE_W-1:0] stage;
	} bqzc_cmd_t;
endpackage

// ===== rtl/bqzc_ifs.sv =====
// Valid/ready channel interfaces for samples and results
interface bqzc_in_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] sample;
	logic              batch_end;

	modport source (output valid, output sample, output batch_end, input ready);
	modport sink (input valid, input sample, input batch_end, output ready);
endinterface

interface bqzc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] filtered;
	logic               crossing;
	logic [31:0]        crossing_count;
	logic               batch_last;

	modport source (output valid, output filtered, output crossing, output crossing_count,
		output batch_last, input ready);
	modport sink (input valid, input filtered, input crossing, input crossing_count,
		input batch_last, output ready);
endinterface

// ===== rtl/bqzc_ctrl.sv =====
// Sequencer for the shared multiply-accumulate datapath
`include "assert_macros.svh"
module bqzc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output bqzc_pkg::bqzc_cmd_t cmd
);
	import bqzc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_LAST,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [TAP_W-1:0]   tap_q;
	logic [STAGE_W-1:0] stage_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.tap      = tap_q;
		cmd.stage    = stage_q;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mul      = (state_q == S_MAC);
		cmd.acc      = ((state_q == S_MAC) && (tap_q != TAP_B0)) || (state_q == S_LAST);
		cmd.fin      = (state_q == S_LAST);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_q       <= TAP_B0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MAC;
						tap_q   <= TAP_B0;
						stage_q <= '0;
					end
				end
				S_MAC: begin
					if (tap_q == TAP_A2)
						state_q <= S_LAST;
					else
						tap_q <= tap_q + TAP_W'(1);
				end
				S_LAST: begin
					tap_q <= TAP_B0;
					if (stage_q == STAGE_W'(STAGES - 1)) begin
						state_q <= S_DONE;
					end else begin
						stage_q <= stage_q + STAGE_W'(1);
						state_q <= S_MAC;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_SAME(a_load_slot_free, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	`ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.out_load, out_valid_q)
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == S_MAC && tap_q == TAP_B0 && stage_q == '0)
	`ASSERT_SAME(a_acc_after_mul, clk, arst_n, cmd.acc, $past(cmd.mul))
endmodule

// ===== rtl/bqzc_dp.sv =====
// Datapath: registers, coefficient/operand select, shared MAC, saturation, run counter
module bqzc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bqzc_pkg::bqzc_cmd_t           cmd,
	input  logic signed [bqzc_pkg::SMP_W-1:0] sample,
	input  logic                          batch_end,
	input  logic                          cfg_we,
	input  logic [bqzc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqzc_pkg::CFG_W-1:0]    cfg_data,
	output logic signed [bqzc_pkg::SMP_W-1:0] filtered,
	output logic                          crossing,
	output logic [bqzc_pkg::CNT_W-1:0]    crossing_count,
	output logic                          batch_last
);
	import bqzc_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	logic [47:0]      s0_ff_q, s1_ff_q;
	logic [31:0]      s0_fb_q, s1_fb_q;
	logic [1:0]       post_sh_q;
	logic [RUN_W-1:0] run_thr_q;

	logic signed [SMP_W-1:0] hist_q [STAGES][4];
	logic signed [SMP_W-1:0] x_q;
	logic                    batch_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic [RUN_W-1:0]        run_q;
	logic [CNT_W-1:0]        cnt_q;

	logic signed [SMP_W-1:0] filt_q;
	logic                    cross_q;
	logic                    last_q;

	logic [47:0]             ff_sel;
	logic [31:0]             fb_sel;
	logic signed [SMP_W-1:0] coef;
	logic signed [SMP_W-1:0] opnd;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [ACC_W-1:0] shifted;
	logic [3:0]              sh;
	logic signed [SMP_W-1:0] y;
	logic [RUN_W-1:0]        run_next;
	logic                    fire;

	always_comb begin
		ff_sel = (cmd.stage == '0) ? s0_ff_q : s1_ff_q;
		fb_sel = (cmd.stage == '0) ? s0_fb_q : s1_fb_q;
		case (cmd.tap)
			TAP_B0: begin coef = ff_sel[15:0];  opnd = x_q; end
			TAP_B1: begin coef = ff_sel[31:16]; opnd = hist_q[cmd.stage][0]; end
			TAP_B2: begin coef = ff_sel[47:32]; opnd = hist_q[cmd.stage][1]; end
			TAP_A1: begin coef = fb_sel[15:0];  opnd = hist_q[cmd.stage][2]; end
			TAP_A2: begin coef = fb_sel[31:16]; opnd = hist_q[cmd.stage][3]; end
			default: begin coef = '0; opnd = '0; end
		endcase
	end

	// accumulate, floor shift, saturate
	always_comb begin
		acc_next = acc_q + ACC_W'(prod_s1);
		sh       = 4'd15 - {2'b00, post_sh_q};
		shifted  = acc_next >>> sh;
		if (shifted > SAT_HI)
			y = SMP_W'(SAT_HI);
		else if (shifted < SAT_LO)
			y = SMP_W'(SAT_LO);
		else
			y = shifted[SMP_W-1:0];
	end

	always_comb begin
		run_next = run_q;
		fire     = 1'b0;
		if (x_q[SMP_W-1]) begin
			run_next = '0;
		end else if (run_q != RUN_MAX) begin
			run_next = run_q + RUN_W'(1);
			fire     = (run_next == run_thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_ff_q   <= S0_FF_RST;
			s0_fb_q   <= S0_FB_RST;
			s1_ff_q   <= S1_FF_RST;
			s1_fb_q   <= S1_FB_RST;
			post_sh_q <= POST_SH_RST;
			run_thr_q <= RUN_THR_RST;
			for (int s = 0; s < STAGES; s++)
				for (int k = 0; k < 4; k++)
					hist_q[s][k] <= '0;
			run_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_S0_FF:   s0_ff_q   <= cfg_data[47:0];
					CFG_S0_FB:   s0_fb_q   <= cfg_data[31:0];
					CFG_S1_FF:   s1_ff_q   <= cfg_data[47:0];
					CFG_S1_FB:   s1_fb_q   <= cfg_data[31:0];
					CFG_POST_SH: post_sh_q <= cfg_data[1:0];
					CFG_RUN_THR: run_thr_q <= cfg_data[RUN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.fin) begin
				hist_q[cmd.stage][1] <= hist_q[cmd.stage][0];
				hist_q[cmd.stage][0] <= x_q;
				hist_q[cmd.stage][3] <= hist_q[cmd.stage][2];
				hist_q[cmd.stage][2] <= y;
			end
			if (cmd.out_load) begin
				run_q <= run_next;
				if (fire)
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= sample;
			batch_q <= batch_end;
		end else if (cmd.fin) begin
			x_q <= y; // section output feeds the next section
		end
		if (cmd.mul)
			prod_s1 <= coef * opnd;
		if (cmd.load || cmd.fin)
			acc_q <= '0;
		else if (cmd.acc)
			acc_q <= acc_next;
		if (cmd.out_load) begin
			filt_q  <= x_q;
			cross_q <= fire;
			last_q  <= batch_q;
		end
	end

	assign filtered       = filt_q;
	assign crossing       = cross_q;
	assign crossing_count = cnt_q;
	assign batch_last     = last_q;
endmodule

// ===== rtl/biquad_bandpass_zero_crossing.sv =====
// Two-section Q15 biquad cascade with rising zero-crossing counter, top level
// One shared 16x16 multiplier works through five products per section, in sequence;
// a new sample is accepted only once the previous result is in the output register.
// The output register holds a result until taken; the next sample waits only for it.
// Reset: clears filter history, run and crossing counters; registers take defaults.
module biquad_bandpass_zero_crossing (
	input  logic                           clk,
	input  logic                           arst_n,
	bqzc_in_if.sink                        in_ch,
	bqzc_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [bqzc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqzc_pkg::CFG_W-1:0]     cfg_data
);
	import bqzc_pkg::*;

	bqzc_cmd_t cmd;
	logic      in_ready;
	logic      out_valid;

	bqzc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	bqzc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sample         (in_ch.sample),
		.batch_end      (in_ch.batch_end),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.filtered       (out_ch.filtered),
		.crossing       (out_ch.crossing),
		.crossing_count (out_ch.crossing_count),
		.batch_last     (out_ch.batch_last)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the biquad cascade with rising zero-crossing counter
`timescale 1ns / 1ps

module tb_top;
	import bqzc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;
	localparam int IDLE_PCT      = 68;
	localparam int BOTH_IDLE_PCT = 23;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 4000;
	localparam int RAND_PHASES   = 8;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {SEG_SQUARE, SEG_NOISE, SEG_EXTREME} seg_kind_t;

	typedef struct packed {
		logic [15:0] filtered;
		logic        crossing;
		logic [31:0] crossing_count;
		logic        batch_last;
	} filt_result_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [15:0]          smp;
		logic                 be;
		logic                 typed;
		filt_result_t         want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bqzc_in_if  in_ch ();
	bqzc_out_if out_ch ();

	biquad_bandpass_zero_crossing uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow registers and filter state
	logic [47:0]        coef_ff [2];
	logic [31:0]        coef_fb [2];
	logic [1:0]         gain_shift;
	logic [7:0]         run_limit;
	logic signed [15:0] taps [8];
	logic [7:0]         run_len;
	logic [31:0]        crossings_total;

	filt_result_t awaited_outputs [$];
	row_t         directed_rows [$];
	int           fail_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		fail_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic void shadow_reset();
		coef_ff[0] = S0_FF_RST;
		coef_fb[0] = S0_FB_RST;
		coef_ff[1] = S1_FF_RST;
		coef_fb[1] = S1_FB_RST;
		gain_shift = POST_SH_RST;
		run_limit = RUN_THR_RST;
		foreach (taps[i])
			taps[i] = '0;
		run_len = '0;
		crossings_total = '0;
	endfunction

	function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] data);
		case (idx)
			CFG_S0_FF: coef_ff[0] = data[47:0];
			CFG_S0_FB: coef_fb[0] = data[31:0];
			CFG_S1_FF: coef_ff[1] = data[47:0];
			CFG_S1_FB: coef_fb[1] = data[31:0];
			CFG_POST_SH: gain_shift = data[1:0];
			CFG_RUN_THR: run_limit = data[7:0];
			default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] section_out(input int st,
		input logic signed [15:0] x);
		longint             acc;
		int                 base;
		logic signed [15:0] y;
		base = st * 4;
		acc = longint'($signed(coef_ff[st][15:0])) * x
			+ longint'($signed(coef_ff[st][31:16])) * taps[base]
			+ longint'($signed(coef_ff[st][47:32])) * taps[base + 1]
			+ longint'($signed(coef_fb[st][15:0])) * taps[base + 2]
			+ longint'($signed(coef_fb[st][31:16])) * taps[base + 3];
		acc = acc >>> (15 - gain_shift);
		if (acc > 32767)
			y = 16'sh7FFF;
		else if (acc < -32768)
			y = 16'sh8000;
		else
			y = acc[15:0];
		taps[base + 1] = taps[base];
		taps[base] = x;
		taps[base + 3] = taps[base + 2];
		taps[base + 2] = y;
		return y;
	endfunction

	function automatic filt_result_t cascade_predict(input logic signed [15:0] s,
		input logic be);
		filt_result_t       r;
		logic signed [15:0] v;
		logic               fire;
		v = s;
		fire = 1'b0;
		for (int st = 0; st < STAGES; st++)
			v = section_out(st, v);
		// run saturates at 255, so a crossing fires at most once per run
		if (v < 0) begin
			run_len = '0;
		end else if (run_len != 8'd255) begin
			run_len = run_len + 8'd1;
			if (run_len == run_limit)
				fire = 1'b1;
		end
		if (fire)
			crossings_total = crossings_total + 32'd1;
		r.filtered = v;
		r.crossing = fire;
		r.crossing_count = crossings_total;
		r.batch_last = be;
		return r;
	endfunction

	function automatic void tbl_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] data);
		row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.smp = '0;
		r.be = 1'b0;
		r.typed = 1'b0;
		r.want = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void tbl_sample(input logic [15:0] s, input logic be,
		input logic typed, input logic [15:0] f, input logic c, input logic [31:0] n);
		row_t r;
		r.kind = ROW_SAMPLE;
		r.idx = '0;
		r.data = '0;
		r.smp = s;
		r.be = be;
		r.typed = typed;
		r.want.filtered = f;
		r.want.crossing = c;
		r.want.crossing_count = n;
		r.want.batch_last = be;
		directed_rows.push_back(r);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		shadow_write(idx, data);
	endtask

	// valid stays high across back-to-back transactions
	task automatic offer_sample(input logic [15:0] s, input logic be);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.batch_end <= be;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic drain_outputs();
		in_ch.valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(input int ph);
		logic [47:0] ff0, ff1;
		logic [31:0] fb0, fb1;
		logic [1:0]  psh;
		logic [7:0]  thr;
		logic [63:0] wide;
		ff0 = S0_FF_RST;
		fb0 = S0_FB_RST;
		ff1 = S1_FF_RST;
		fb1 = S1_FB_RST;
		psh = POST_SH_RST;
		thr = RUN_THR_RST;
		case (ph)
			1, 5: begin
				// unity pass-through: b0 = 0.5 scaled back by the post shift
				ff0 = 48'h0000_0000_4000;
				ff1 = 48'h0000_0000_4000;
				fb0 = '0;
				fb1 = '0;
				psh = 2'd1;
				thr = (ph == 1) ? 8'd255 : 8'($urandom_range(40, 2));
			end
			2, 6: begin
				wide = {$urandom, $urandom};
				ff0 = wide[47:0];
				wide = {$urandom, $urandom};
				ff1 = wide[47:0];
				fb0 = $urandom;
				fb1 = $urandom;
				psh = (ph == 2) ? 2'($urandom_range(3)) : 2'd0;
				thr = 8'($urandom_range(8, 1));
			end
			3: thr = 8'($urandom_range(16, 1));
			4: begin
				ff0 = 48'h8000_8000_8000;
				ff1 = 48'h8000_8000_8000;
				fb0 = 32'h8000_8000;
				fb1 = 32'h8000_8000;
				psh = 2'd3;
				thr = 8'd1;
			end
			7: begin
				ff0 = '1;
				ff1 = '1;
				fb0 = '1;
				fb1 = '1;
				psh = 2'd2;
				thr = 8'd2;
			end
			default: ;
		endcase
		cfg_write(CFG_S0_FF, CFG_W'(ff0));
		cfg_write(CFG_S0_FB, CFG_W'(fb0));
		cfg_write(CFG_S1_FF, CFG_W'(ff1));
		cfg_write(CFG_S1_FB, CFG_W'(fb1));
		cfg_write(CFG_POST_SH, CFG_W'(psh));
		cfg_write(CFG_RUN_THR, CFG_W'(thr));
	endtask

	always @(posedge clk)
		out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		filt_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_outputs.size() == 0) begin
				flag_mismatch($sformatf("result with nothing awaited, filtered %0d",
					$signed(out_ch.filtered)));
			end else begin
				want = awaited_outputs.pop_front();
				if (out_ch.filtered !== want.filtered)
					flag_mismatch($sformatf("filtered got %0d want %0d",
						$signed(out_ch.filtered), $signed(want.filtered)));
				if (out_ch.crossing !== want.crossing)
					flag_mismatch($sformatf("crossing got %b want %b",
						out_ch.crossing, want.crossing));
				if (out_ch.crossing_count !== want.crossing_count)
					flag_mismatch($sformatf("crossing_count got %0d want %0d",
						out_ch.crossing_count, want.crossing_count));
				if (out_ch.batch_last !== want.batch_last)
					flag_mismatch($sformatf("batch_last got %b want %b",
						out_ch.batch_last, want.batch_last));
			end
		end
	end

	// ends the run when no transaction moves for too long
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		row_t               row;
		filt_result_t       pred;
		int                 item_total, pick, seg_left, half_len, half_pos;
		seg_kind_t          seg;
		logic signed [15:0] amp, smp;
		logic               hi_half, be, busy;

		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.sample <= '0;
		in_ch.batch_end <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		shadow_reset();
		seg = SEG_NOISE;
		amp = '0;
		hi_half = 1'b0;
		half_len = 1;
		half_pos = 0;

		// after reset: zero input keeps every stage at zero, run of 3 fires
		tbl_sample(16'sd0, 1'b0, 1'b1, 16'sd0, 1'b0, 32'd0);
		tbl_sample(16'sd0, 1'b1, 1'b1, 16'sd0, 1'b0, 32'd0);
		tbl_sample(16'sd0, 1'b0, 1'b1, 16'sd0, 1'b1, 32'd1);
		tbl_sample(16'sd0, 1'b0, 1'b1, 16'sd0, 1'b0, 32'd1);
		// b0 only at full scale, max post shift: both extremes saturate
		tbl_write(CFG_S0_FF, 48'h0000_0000_7FFF);
		tbl_write(CFG_S0_FB, 48'h0);
		tbl_write(CFG_S1_FF, 48'h0000_0000_7FFF);
		tbl_write(CFG_S1_FB, 48'h0);
		tbl_write(CFG_POST_SH, 48'd3);
		tbl_write(CFG_RUN_THR, 48'd1);
		tbl_sample(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF, 1'b0, 32'd1);
		tbl_sample(16'sh8000, 1'b1, 1'b1, 16'sh8000, 1'b0, 32'd1);
		tbl_sample(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF, 1'b1, 32'd2);
		tbl_sample(16'sd0, 1'b0, 1'b1, 16'sd0, 1'b0, 32'd2);
		tbl_sample(16'shFFFF, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sd1, 1'b0, 1'b0, '0, 1'b0, '0);
		// zero post shift, threshold zeroed by an oversized value, spare indexes
		tbl_write(CFG_POST_SH, 48'd0);
		tbl_write(CFG_RUN_THR, 48'hFFFF_FFFF_FF00);
		tbl_write(CFG_SPARE6, 48'hFFFF_FFFF_FFFF);
		tbl_write(CFG_SPARE7, 48'h0000_0000_0001);
		tbl_sample(16'sh7FFF, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sh8000, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sh5555, 1'b1, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'shAAAA, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sd12345, 1'b0, 1'b0, '0, 1'b0, '0);
		// back to the band-pass default coefficients and post shift, upper bits of wide writes dropped
		tbl_write(CFG_S0_FF, S0_FF_RST);
		tbl_write(CFG_S0_FB, {16'h0000, S0_FB_RST});
		tbl_write(CFG_S1_FF, S1_FF_RST);
		tbl_write(CFG_S1_FB, {16'hFFFF, S1_FB_RST});
		tbl_write(CFG_POST_SH, 48'hFFFF_FFFF_FFFD);
		tbl_write(CFG_RUN_THR, 48'd255);
		tbl_sample(16'sd1000, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sd1000, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(-16'sd1000, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(-16'sd1000, 1'b1, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sh7FFF, 1'b0, 1'b0, '0, 1'b0, '0);
		tbl_sample(16'sh8000, 1'b0, 1'b0, '0, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		busy = 1'b0;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				if (busy) begin
					drain_outputs();
					busy = 1'b0;
				end
				cfg_write(row.idx, row.data);
			end else begin
				offer_sample(row.smp, row.be);
				pred = cascade_predict(row.smp, row.be);
				awaited_outputs.push_back(row.typed ? row.want : pred);
				busy = 1'b1;
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_outputs();
			load_setting(ph);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = IDLE_PCT;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = IDLE_PCT;
				end
				default: begin
					send_idle_pct = BOTH_IDLE_PCT;
					recv_stall_pct = BOTH_IDLE_PCT;
				end
			endcase
			seg_left = 0;
			item_total = (ph == 1) ? 300 : 65;
			for (int n = 0; n < item_total; n++) begin
				if (seg_left == 0) begin
					pick = (ph == 1) ? 0 : $urandom_range(99);
					if (pick < 70) begin
						seg = SEG_SQUARE;
						// long positive half-waves drive the run up to its saturation at 255
						if (ph == 1) begin
							half_len = $urandom_range(300, 250);
							hi_half = 1'b1;
						end else begin
							half_len = $urandom_range(40, 1);
							hi_half = 1'($urandom_range(1));
						end
						amp = 16'($urandom_range(32767, 1));
						half_pos = 0;
						seg_left = half_len * $urandom_range(4, 2);
					end else if (pick < 90) begin
						seg = SEG_NOISE;
						seg_left = $urandom_range(20, 1);
					end else begin
						seg = SEG_EXTREME;
						seg_left = $urandom_range(8, 1);
					end
				end
				case (seg)
					SEG_SQUARE: begin
						smp = hi_half ? amp : -amp;
						half_pos = half_pos + 1;
						if (half_pos == half_len) begin
							half_pos = 0;
							hi_half = !hi_half;
						end
					end
					SEG_NOISE: smp = 16'($urandom);
					default: smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				endcase
				seg_left = seg_left - 1;
				be = ($urandom_range(7) == 0);
				offer_sample(smp, be);
				awaited_outputs.push_back(cascade_predict(smp, be));
			end
		end

		in_ch.valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
